// ----- rtl/core/hjp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjp_pkg
// Shared types and constants of the hash-join probe engine.
// ----------------------------------------------------------------------------
package hjp_pkg;

    // Table geometry, tied to the widths of the entry and word index fields
    localparam int TABLE_ENTRIES = 1024;
    localparam int MAX_KEY_WORDS = 8;

    // Multiplier of the 32-bit MurmurHash1 mix
    localparam logic [31:0] MURMUR_M = 32'hc6a4a793;

    // Result status codes
    localparam logic [1:0] ST_FOUND       = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_NO_MATCH    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_WORDS   = 2'd0;
    localparam logic [1:0] CFG_ENTRY_COUNT = 2'd1;
    localparam logic [1:0] CFG_WIDE_MODE   = 2'd2;
    localparam logic [1:0] CFG_EMPTY_KEY   = 2'd3;

    // Input item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // Header of a command passed from front to back
    typedef struct packed {
        logic       is_lookup;
        logic       no_slots;
        logic [3:0] word_index;
    } hjp_cmd_hdr_t;

    localparam int HDR_W = $bits(hjp_cmd_hdr_t);

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_INIT,
        FR_MIX,
        FR_FIN1,
        FR_FIN2,
        FR_DIV,
        FR_PUSH
    } hjp_front_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SETUP,
        BK_ADDR,
        BK_CMP,
        BK_EVAL,
        BK_PLO_A,
        BK_PLO,
        BK_PHI_A,
        BK_PHI,
        BK_OUT
    } hjp_back_state_t;

endpackage

// ----- rtl/core/hjp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjp_fifo
// Two-entry command queue between the front and back of the probe engine.
// ----------------------------------------------------------------------------
module hjp_fifo #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              not_empty
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Store pushed beats
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/core/hjp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjp_front
// Accepts beats, collects key words, hashes the key and reduces it to a
// start slot, then queues load and lookup commands.
// ----------------------------------------------------------------------------
module hjp_front #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int MAX_KEY_WORDS = 8,
    parameter int SLOT_W        = 10,
    parameter int KW_W          = 4,
    parameter int N_W           = 11,
    parameter int DATA_W        = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [9:0]        s_entry_index,
    input  logic [3:0]        s_word_index,
    input  logic [31:0]       s_data_word,
    input  logic              s_last_key_word,
    input  logic [KW_W-1:0]   kw_eff,
    input  logic [N_W-1:0]    n_eff,
    input  logic              fifo_full,
    output logic              push,
    output logic [DATA_W-1:0] push_data
);

    localparam int IW    = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
    localparam int KC_W  = $clog2(MAX_KEY_WORDS + 1);
    localparam int KEY_W = MAX_KEY_WORDS * 32;

    hjp_pkg::hjp_front_state_t state_reg, state_next;

    logic [31:0]     key_buf_reg [MAX_KEY_WORDS];
    logic [KC_W-1:0] key_cnt_reg;
    logic [31:0]     hash_reg;
    logic [KC_W-1:0] idx_reg;
    logic [N_W-1:0]  rem_reg;
    logic [4:0]      div_cnt_reg;

    logic              accept;
    logic              load_ok;
    logic [31:0]       mul_a;
    logic [31:0]       mul_p;
    logic [N_W:0]      rem_shift;
    logic [N_W:0]      rem_sub;
    logic [KEY_W-1:0]  key_vec;
    hjp_pkg::hjp_cmd_hdr_t hdr;

    assign accept  = s_valid && s_ready;
    assign load_ok = (s_mode == hjp_pkg::MODE_LOAD)
                     && (32'(s_entry_index) < TABLE_ENTRIES)
                     && (32'(s_word_index) < MAX_KEY_WORDS + 2);

    // Shared hash multiplier
    always_comb begin
        case (state_reg)
            hjp_pkg::FR_INIT: mul_a = 32'(kw_eff) << 2;
            hjp_pkg::FR_MIX:  mul_a = hash_reg + key_buf_reg[idx_reg[IW-1:0]];
            default:          mul_a = hash_reg;
        endcase
    end
    assign mul_p = mul_a * hjp_pkg::MURMUR_M;

    // One restoring division step
    assign rem_shift = {rem_reg, hash_reg[31]};
    assign rem_sub   = (rem_shift >= {1'b0, n_eff}) ? rem_shift - {1'b0, n_eff} : rem_shift;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hjp_pkg::FR_IDLE: begin
                if (accept && s_mode == hjp_pkg::MODE_LOOKUP && s_last_key_word) begin
                    state_next = hjp_pkg::FR_INIT;
                end
            end
            hjp_pkg::FR_INIT: begin
                state_next = (kw_eff == '0) ? hjp_pkg::FR_FIN1 : hjp_pkg::FR_MIX;
            end
            hjp_pkg::FR_MIX: begin
                if ((32'(idx_reg) + 1) == 32'(kw_eff)) begin
                    state_next = hjp_pkg::FR_FIN1;
                end
            end
            hjp_pkg::FR_FIN1: state_next = hjp_pkg::FR_FIN2;
            hjp_pkg::FR_FIN2: begin
                state_next = (n_eff == '0) ? hjp_pkg::FR_PUSH : hjp_pkg::FR_DIV;
            end
            hjp_pkg::FR_DIV: begin
                if (div_cnt_reg == 5'd31) begin
                    state_next = hjp_pkg::FR_PUSH;
                end
            end
            hjp_pkg::FR_PUSH: begin
                if (!fifo_full) begin
                    state_next = hjp_pkg::FR_IDLE;
                end
            end
            default: state_next = hjp_pkg::FR_IDLE;
        endcase
    end

    // Pack the key buffer for the queue
    always_comb begin
        for (int i = 0; i < MAX_KEY_WORDS; i++) begin
            key_vec[32*i +: 32] = key_buf_reg[i];
        end
    end

    // Outputs: handshake and queue push
    always_comb begin
        s_ready   = 1'b0;
        push      = 1'b0;
        hdr       = '0;
        push_data = '0;
        unique case (state_reg)
            hjp_pkg::FR_IDLE: begin
                s_ready        = !fifo_full;
                push           = accept && load_ok;
                hdr.is_lookup  = 1'b0;
                hdr.word_index = s_word_index;
                push_data      = {hdr, SLOT_W'(s_entry_index), KEY_W'(s_data_word)};
            end
            hjp_pkg::FR_PUSH: begin
                push           = !fifo_full;
                hdr.is_lookup  = 1'b1;
                hdr.no_slots   = (n_eff == '0);
                push_data      = {hdr, SLOT_W'(rem_reg), key_vec};
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hjp_pkg::FR_IDLE;
            key_cnt_reg <= '0;
            for (int i = 0; i < MAX_KEY_WORDS; i++) begin
                key_buf_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            // Collect key words, drop those past the buffer
            if (accept && s_mode == hjp_pkg::MODE_LOOKUP
                && 32'(key_cnt_reg) < MAX_KEY_WORDS) begin
                key_buf_reg[key_cnt_reg[IW-1:0]] <= s_data_word;
                key_cnt_reg <= key_cnt_reg + 1'b1;
            end
            // Clear the buffer once the lookup is queued
            if (state_reg == hjp_pkg::FR_PUSH && !fifo_full) begin
                key_cnt_reg <= '0;
                for (int i = 0; i < MAX_KEY_WORDS; i++) begin
                    key_buf_reg[i] <= '0;
                end
            end
        end
    end

    // Hash and division datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            hjp_pkg::FR_INIT: begin
                hash_reg <= mul_p;
                idx_reg  <= '0;
            end
            hjp_pkg::FR_MIX: begin
                hash_reg <= mul_p ^ (mul_p >> 16);
                idx_reg  <= idx_reg + 1'b1;
            end
            hjp_pkg::FR_FIN1: hash_reg <= mul_p ^ (mul_p >> 10);
            hjp_pkg::FR_FIN2: begin
                hash_reg    <= mul_p ^ (mul_p >> 17);
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            hjp_pkg::FR_DIV: begin
                rem_reg     <= rem_sub[N_W-1:0];
                hash_reg    <= hash_reg << 1;
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            default: begin
                hash_reg <= hash_reg;
            end
        endcase
    end

endmodule

// ----- rtl/core/hjp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjp_back
// Owns the table memory: writes load commands and walks the probe sequence
// of lookup commands, one table word per read.
// ----------------------------------------------------------------------------
module hjp_back #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int MAX_KEY_WORDS = 8,
    parameter int SLOT_W        = 10,
    parameter int KW_W          = 4,
    parameter int N_W           = 11,
    parameter int DATA_W        = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    input  logic [DATA_W-1:0] cmd_data,
    output logic              cmd_pop,
    input  logic [KW_W-1:0]   kw_eff,
    input  logic [N_W-1:0]    n_eff,
    input  logic              wide_mode,
    input  logic [63:0]       empty_key_marker,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic signed [63:0] m_payload
);

    localparam int SLOT_WORDS = MAX_KEY_WORDS + 2;
    localparam int DEPTH      = TABLE_ENTRIES * SLOT_WORDS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int W_W        = $clog2(SLOT_WORDS);
    localparam int IW         = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
    localparam int KEY_W      = MAX_KEY_WORDS * 32;

    hjp_pkg::hjp_back_state_t state_reg, state_next;

    logic [31:0]       mem [DEPTH];
    logic [31:0]       rd_data_reg;

    logic [KEY_W-1:0]  key_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [W_W-1:0]    w_reg;
    logic [N_W-1:0]    probe_cnt_reg;
    logic              match_reg;
    logic [31:0]       w0_reg;
    logic [31:0]       w1_reg;
    logic [31:0]       plo_reg;
    logic [1:0]        res_status_reg;
    logic [63:0]       res_payload_reg;
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [63:0]       m_payload_reg;

    hjp_pkg::hjp_cmd_hdr_t cmd_hdr;
    logic [SLOT_W-1:0] cmd_slot;
    logic [KEY_W-1:0]  cmd_key;

    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic              mem_re;
    logic [ADDR_W-1:0] rd_addr;
    logic [W_W-1:0]    last_w;
    logic              word_differs;
    logic              is_empty;
    logic              last_probe;
    logic              wrap;
    logic              out_free;

    assign {cmd_hdr, cmd_slot, cmd_key} = cmd_data;

    assign last_w = (32'(kw_eff) > 2) ? W_W'(kw_eff) - 1'b1 : W_W'(1);
    assign word_differs = (32'(w_reg) < 32'(kw_eff))
                          && (rd_data_reg != key_reg[32*w_reg[IW-1:0] +: 32]);
    assign is_empty = wide_mode ? ({w1_reg, w0_reg} == empty_key_marker)
                                : (w0_reg == empty_key_marker[31:0]);
    assign last_probe = ((32'(probe_cnt_reg) + 1) == 32'(n_eff));
    assign wrap       = ((32'(slot_reg) + 1) == 32'(n_eff));
    assign out_free   = !m_valid_reg || m_ready;

    // Table memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= cmd_key[31:0];
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hjp_pkg::BK_IDLE: begin
                if (cmd_valid && cmd_hdr.is_lookup) begin
                    state_next = cmd_hdr.no_slots ? hjp_pkg::BK_OUT : hjp_pkg::BK_SETUP;
                end
            end
            hjp_pkg::BK_SETUP: state_next = hjp_pkg::BK_ADDR;
            hjp_pkg::BK_ADDR:  state_next = hjp_pkg::BK_CMP;
            hjp_pkg::BK_CMP: begin
                state_next = (w_reg == last_w) ? hjp_pkg::BK_EVAL : hjp_pkg::BK_ADDR;
            end
            hjp_pkg::BK_EVAL: begin
                if (match_reg) begin
                    state_next = hjp_pkg::BK_PLO_A;
                end else if (is_empty || last_probe) begin
                    state_next = hjp_pkg::BK_OUT;
                end else begin
                    state_next = hjp_pkg::BK_ADDR;
                end
            end
            hjp_pkg::BK_PLO_A: state_next = hjp_pkg::BK_PLO;
            hjp_pkg::BK_PLO:   state_next = hjp_pkg::BK_PHI_A;
            hjp_pkg::BK_PHI_A: state_next = hjp_pkg::BK_PHI;
            hjp_pkg::BK_PHI:   state_next = hjp_pkg::BK_OUT;
            hjp_pkg::BK_OUT: begin
                if (out_free) begin
                    state_next = hjp_pkg::BK_IDLE;
                end
            end
            default: state_next = hjp_pkg::BK_IDLE;
        endcase
    end

    // Outputs: queue pop and memory ports
    always_comb begin
        cmd_pop = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        wr_addr = ADDR_W'(32'(cmd_slot) * SLOT_WORDS + 32'(cmd_hdr.word_index));
        rd_addr = base_reg + ADDR_W'(w_reg);
        unique case (state_reg)
            hjp_pkg::BK_IDLE: begin
                cmd_pop = cmd_valid;
                mem_we  = cmd_valid && !cmd_hdr.is_lookup;
            end
            hjp_pkg::BK_ADDR: mem_re = 1'b1;
            hjp_pkg::BK_PLO_A: begin
                mem_re  = 1'b1;
                rd_addr = base_reg + ADDR_W'(MAX_KEY_WORDS);
            end
            hjp_pkg::BK_PHI_A: begin
                mem_re  = 1'b1;
                rd_addr = base_reg + ADDR_W'(MAX_KEY_WORDS + 1);
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Probe datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            hjp_pkg::BK_IDLE: begin
                key_reg         <= cmd_key;
                slot_reg        <= cmd_slot;
                res_status_reg  <= hjp_pkg::ST_NO_MATCH;
                res_payload_reg <= '0;
            end
            hjp_pkg::BK_SETUP: begin
                base_reg      <= ADDR_W'(32'(slot_reg) * SLOT_WORDS);
                w_reg         <= '0;
                match_reg     <= 1'b1;
                probe_cnt_reg <= '0;
            end
            hjp_pkg::BK_CMP: begin
                if (word_differs) begin
                    match_reg <= 1'b0;
                end
                if (w_reg == W_W'(0)) begin
                    w0_reg <= rd_data_reg;
                end
                if (w_reg == W_W'(1)) begin
                    w1_reg <= rd_data_reg;
                end
                w_reg <= w_reg + 1'b1;
            end
            hjp_pkg::BK_EVAL: begin
                if (!match_reg) begin
                    if (is_empty) begin
                        res_status_reg <= hjp_pkg::ST_NOT_PRESENT;
                    end
                    // Step to the next slot with wrap
                    if (wrap) begin
                        slot_reg <= '0;
                        base_reg <= '0;
                    end else begin
                        slot_reg <= slot_reg + 1'b1;
                        base_reg <= base_reg + ADDR_W'(SLOT_WORDS);
                    end
                    probe_cnt_reg <= probe_cnt_reg + 1'b1;
                    w_reg         <= '0;
                    match_reg     <= 1'b1;
                end
            end
            hjp_pkg::BK_PLO: plo_reg <= rd_data_reg;
            hjp_pkg::BK_PHI: begin
                res_status_reg  <= hjp_pkg::ST_FOUND;
                res_payload_reg <= wide_mode ? {rd_data_reg, plo_reg}
                                             : {{32{plo_reg[31]}}, plo_reg};
            end
            default: begin
                w_reg <= w_reg;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hjp_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == hjp_pkg::BK_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == hjp_pkg::BK_OUT && out_free) begin
            m_status_reg  <= res_status_reg;
            m_payload_reg <= res_payload_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_payload = m_payload_reg;

endmodule

// ----- rtl/core/hash_join_probe_linear.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_join_probe_linear
// Hash-join probe engine over an open-addressing table with linear probing.
// ----------------------------------------------------------------------------
// A load beat writes one 32-bit table word. Key beats are taken one per cycle
// while the front is idle and the queue has room; after the last key beat the
// front runs the shared hash multiplier once over the key length, once per
// key word with a mix, twice to finalize, then a bit-serial modulo of 32 steps
// (skipped with no slots), and takes no beat meanwhile. The back then reads
// max(key_words, 2) words of each probed slot, one per access of the single
// read port of the table memory, then fetches the payload words of a match and
// registers the result. A two-entry queue lets the front hash the next key and
// take loads while the back is still probing; a waiting result stalls the input
// only once that queue has filled. Reset does not clear the table.
module hash_join_probe_linear (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [9:0]         s_entry_index,
    input  logic [3:0]         s_word_index,
    input  logic [31:0]        s_data_word,
    input  logic               s_last_key_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [63:0] m_payload
);

    localparam int TABLE_ENTRIES = hjp_pkg::TABLE_ENTRIES;
    localparam int MAX_KEY_WORDS = hjp_pkg::MAX_KEY_WORDS;
    localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int KW_W   = $clog2(MAX_KEY_WORDS + 1);
    localparam int N_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int DATA_W = hjp_pkg::HDR_W + SLOT_W + MAX_KEY_WORDS * 32;

    logic [3:0]  key_words_reg;
    logic [10:0] entry_count_reg;
    logic        wide_mode_reg;
    logic [63:0] empty_key_marker_reg;

    logic [KW_W-1:0]   kw_eff;
    logic [N_W-1:0]    n_eff;
    logic              fifo_full;
    logic              push;
    logic [DATA_W-1:0] push_data;
    logic              pop;
    logic [DATA_W-1:0] pop_data;
    logic              not_empty;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_words_reg        <= 4'd2;
            entry_count_reg      <= 11'd0;
            wide_mode_reg        <= 1'b1;
            empty_key_marker_reg <= 64'h7FFF_FFFF_FFFF_FFFF;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hjp_pkg::CFG_KEY_WORDS:   key_words_reg        <= cfg_data[3:0];
                hjp_pkg::CFG_ENTRY_COUNT: entry_count_reg      <= cfg_data[10:0];
                hjp_pkg::CFG_WIDE_MODE:   wide_mode_reg        <= cfg_data[0];
                hjp_pkg::CFG_EMPTY_KEY:   empty_key_marker_reg <= cfg_data;
                default:                  wide_mode_reg        <= wide_mode_reg;
            endcase
        end
    end

    // Saturate key length and slot count
    assign kw_eff = (32'(key_words_reg) > MAX_KEY_WORDS) ? KW_W'(MAX_KEY_WORDS)
                                                        : KW_W'(key_words_reg);
    assign n_eff  = (32'(entry_count_reg) > TABLE_ENTRIES) ? N_W'(TABLE_ENTRIES)
                                                          : N_W'(entry_count_reg);

    hjp_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_KEY_WORDS (MAX_KEY_WORDS),
        .SLOT_W        (SLOT_W),
        .KW_W          (KW_W),
        .N_W           (N_W),
        .DATA_W        (DATA_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_entry_index   (s_entry_index),
        .s_word_index    (s_word_index),
        .s_data_word     (s_data_word),
        .s_last_key_word (s_last_key_word),
        .kw_eff          (kw_eff),
        .n_eff           (n_eff),
        .fifo_full       (fifo_full),
        .push            (push),
        .push_data       (push_data)
    );

    hjp_fifo #(
        .DATA_W (DATA_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    hjp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_KEY_WORDS (MAX_KEY_WORDS),
        .SLOT_W        (SLOT_W),
        .KW_W          (KW_W),
        .N_W           (N_W),
        .DATA_W        (DATA_W)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (not_empty),
        .cmd_data         (pop_data),
        .cmd_pop          (pop),
        .kw_eff           (kw_eff),
        .n_eff            (n_eff),
        .wide_mode        (wide_mode_reg),
        .empty_key_marker (empty_key_marker_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_payload        (m_payload)
    );

endmodule

// ----- rtl/core/hjp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hjp_checker
// Port-level checks of the probe engine, bound to the top level.
// ----------------------------------------------------------------------------
module hjp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic signed [63:0] m_payload
);

    // No result beat right after reset
    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown right after reset");

    // Hold an input beat that is not taken yet
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input beat withdrawn before acceptance");

    // Hold a stalled result beat
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_payload))
        else $error("stalled result beat changed");

    // Status is one of the three codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == hjp_pkg::ST_FOUND) || (m_status == hjp_pkg::ST_NOT_PRESENT)
                    || (m_status == hjp_pkg::ST_NO_MATCH))
        else $error("undefined status code");

    // Payload is zero unless the key was found
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != hjp_pkg::ST_FOUND) |-> (m_payload == 64'sd0))
        else $error("payload nonzero without a match");

endmodule

bind hash_join_probe_linear hjp_checker u_hjp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_status  (m_status),
    .m_payload (m_payload)
);
